// ===== hw/rtl/p9c_pkg.sv =====
package p9c_pkg;

	localparam int LFSR_W    = 9;
	localparam int THR_W     = 16;
	localparam int TALLY_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 9'h001;
	localparam logic [THR_W-1:0]  THR_RESET = 16'd18;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOSS_THRESHOLD = 2'd1;

	// Control from the sync logic to the sequence generator.
	typedef struct packed {
		logic reseed;
		logic step;
	} lfsr_ctl_t;

	// One result beat.
	typedef struct packed {
		logic               locked;
		logic               bit_mismatch;
		logic [TALLY_W-1:0] errors_seen;
		logic [TALLY_W-1:0] matches_seen;
	} result_t;

endpackage

// ===== hw/rtl/p9c_lfsr.sv =====
module p9c_lfsr
	import p9c_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  lfsr_ctl_t ctl,
	output logic      expected
);

	logic [LFSR_W-1:0] lfsr_q;

	// Taps of x^9 + x^5 + 1.
	assign expected = lfsr_q[8] ^ lfsr_q[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_SEED;
		end else if (ctl.reseed) begin
			lfsr_q <= LFSR_SEED;
		end else if (ctl.step) begin
			lfsr_q <= {lfsr_q[LFSR_W-2:0], expected};
		end
	end

endmodule

// ===== hw/rtl/p9c_sync.sv =====
module p9c_sync
	import p9c_pkg::*;
#(
	parameter int COUNTER_WIDTH = 16
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic             rx_bit,
	input  logic             restart,
	input  logic             expected,
	input  logic [THR_W-1:0] sync_threshold,
	input  logic [THR_W-1:0] loss_threshold,
	output lfsr_ctl_t        ctl,
	output result_t          res
);

	localparam int CMP_W = (COUNTER_WIDTH > THR_W) ? COUNTER_WIDTH : THR_W;

	logic                     sync_q;
	logic [COUNTER_WIDTH-1:0] match_run_q;
	logic [COUNTER_WIDTH-1:0] mismatch_run_q;
	logic [COUNTER_WIDTH-1:0] error_tally_q;
	logic [COUNTER_WIDTH-1:0] match_tally_q;

	logic                     diff;
	logic                     sync_d;
	logic [COUNTER_WIDTH-1:0] match_run_d;
	logic [COUNTER_WIDTH-1:0] mismatch_run_d;
	logic [COUNTER_WIDTH-1:0] error_tally_d;
	logic [COUNTER_WIDTH-1:0] match_tally_d;
	logic [CMP_W-1:0]         err_ext;
	logic [CMP_W-1:0]         mat_ext;

	always_comb begin
		diff           = 1'b0;
		sync_d         = sync_q;
		match_run_d    = match_run_q;
		mismatch_run_d = mismatch_run_q;
		error_tally_d  = error_tally_q;
		match_tally_d  = match_tally_q;
		ctl.reseed     = 1'b0;
		ctl.step       = 1'b0;

		if (restart) begin
			// The runs and tallies are held across a restart.
			sync_d     = 1'b0;
			ctl.reseed = fire;
		end else begin
			diff = rx_bit ^ expected;
			if (diff) begin
				mismatch_run_d = mismatch_run_q + 1'b1;
				match_run_d    = '0;
			end else begin
				match_run_d    = match_run_q + 1'b1;
				mismatch_run_d = '0;
			end

			if (!sync_q) begin
				error_tally_d = '0;
				match_tally_d = '0;
				sync_d = ~diff &&
					(CMP_W'(match_run_d) >= CMP_W'(sync_threshold));
				// A miss while hunting starts the sequence over.
				ctl.reseed = fire & diff;
				ctl.step   = fire & ~diff;
			end else begin
				sync_d   = ~(CMP_W'(mismatch_run_d) >= CMP_W'(loss_threshold));
				ctl.step = fire;
				if (diff) begin
					error_tally_d = error_tally_q + 1'b1;
				end else begin
					match_tally_d = match_tally_q + 1'b1;
				end
			end
		end
	end

	assign err_ext = CMP_W'(error_tally_d);
	assign mat_ext = CMP_W'(match_tally_d);

	assign res.locked       = sync_d;
	assign res.bit_mismatch = diff;
	assign res.errors_seen  = err_ext[TALLY_W-1:0];
	assign res.matches_seen = mat_ext[TALLY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q         <= 1'b0;
			match_run_q    <= '0;
			mismatch_run_q <= '0;
			error_tally_q  <= '0;
			match_tally_q  <= '0;
		end else if (fire) begin
			sync_q         <= sync_d;
			match_run_q    <= match_run_d;
			mismatch_run_q <= mismatch_run_d;
			error_tally_q  <= error_tally_d;
			match_tally_q  <= match_tally_d;
		end
	end

endmodule

// ===== hw/rtl/prbs9_sync_error_checker_top.sv =====
// PRBS9 receive checker: each input beat carries one received bit, which is
// compared against a local x^9+x^5+1 sequence (seed 1); the result beat
// reports lock, whether this bit missed, and the error and match tallies
// counted since lock. One bit is taken every clock unless the output stalls,
// and a result passes through an input register, then a result register;
// the run counter increment and threshold compare sit between the two.
// Thresholds are written on the cfg port, which is always ready, and should
// only be changed while no beat is in flight.
module prbs9_sync_error_checker_top
	import p9c_pkg::*;
#(
	parameter int COUNTER_WIDTH = 16
)
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 rx_bit,
	input  logic                 restart,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 locked,
	output logic                 bit_mismatch,
	output logic [TALLY_W-1:0]   errors_seen,
	output logic [TALLY_W-1:0]   matches_seen,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data
);

	logic             valid_s1;
	logic             rx_bit_s1;
	logic             restart_s1;
	logic             out_valid_q;
	result_t          res_q;
	logic [THR_W-1:0] sync_threshold_q;
	logic [THR_W-1:0] loss_threshold_q;

	logic             advance;
	logic             fire;
	logic             expected;
	lfsr_ctl_t        lfsr_ctl;
	result_t          res;

	assign advance  = ~out_valid_q | ~out_stall;
	assign fire     = valid_s1 & advance;
	assign in_stall = valid_s1 & ~advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_threshold_q <= THR_RESET;
			loss_threshold_q <= THR_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SYNC_THRESHOLD: sync_threshold_q <= cfg_data;
				REG_LOSS_THRESHOLD: loss_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_bit_s1  <= rx_bit;
			restart_s1 <= restart;
		end
	end

	p9c_lfsr u_lfsr (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lfsr_ctl),
		.expected (expected)
	);

	p9c_sync #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_sync (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.rx_bit         (rx_bit_s1),
		.restart        (restart_s1),
		.expected       (expected),
		.sync_threshold (sync_threshold_q),
		.loss_threshold (loss_threshold_q),
		.ctl            (lfsr_ctl),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign locked       = res_q.locked;
	assign bit_mismatch = res_q.bit_mismatch;
	assign errors_seen  = res_q.errors_seen;
	assign matches_seen = res_q.matches_seen;

endmodule

// ===== dv/prbs9_sync_error_checker_top_tb.sv =====
module prbs9_sync_error_checker_top_tb
	import p9c_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT     = 500000;
	localparam int unsigned PHASE_COUNT     = 8;
	localparam int unsigned ITEMS_PER_PHASE = 204;
	localparam int unsigned REPORT_LIMIT    = 10;
	localparam int unsigned SETTLE_CYCLES   = 4;

	typedef enum logic [2:0] {
		ROW_FOLLOW,
		ROW_FLIP,
		ROW_RAW,
		ROW_RESTART,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic               raw;
		logic               typed;
		result_t            want;
		logic [THR_W-1:0]   sync_thr;
		logic [THR_W-1:0]   loss_thr;
	} row_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic                 rx_bit       = 1'b0;
	logic                 restart      = 1'b0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic                 locked;
	logic                 bit_mismatch;
	logic [TALLY_W-1:0]   errors_seen;
	logic [TALLY_W-1:0]   matches_seen;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = REG_SYNC_THRESHOLD;
	logic [THR_W-1:0]     cfg_data     = '0;

	// Local copy of the receiver state and its thresholds.
	logic [LFSR_W-1:0]  lfsr_model = LFSR_SEED;
	logic               lock_model = 1'b0;
	logic [TALLY_W-1:0] hit_run    = '0;
	logic [TALLY_W-1:0] miss_run   = '0;
	logic [TALLY_W-1:0] err_tally  = '0;
	logic [TALLY_W-1:0] hit_tally  = '0;
	logic [THR_W-1:0]   sync_thr   = THR_RESET;
	logic [THR_W-1:0]   loss_thr   = THR_RESET;

	result_t     status_due [$];
	int unsigned fault_count = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_mode  = 0;
	int unsigned stall_left  = 0;

	int unsigned phase_sync [PHASE_COUNT] = '{18, 1, 0, 65535, 2, 40, 0, 0};
	int unsigned phase_loss [PHASE_COUNT] = '{18, 1, 0, 65535, 65535, 1, 0, 0};

	row_t directed_rows [28] = '{
		'{ROW_RESTART, 1'b1, 1'b1, {1'b0, 1'b0, 16'd0, 16'd0}, 16'd0, 16'd0},
		'{ROW_RAW,     1'b1, 1'b1, {1'b0, 1'b1, 16'd0, 16'd0}, 16'd0, 16'd0},
		'{ROW_RAW,     1'b0, 1'b1, {1'b0, 1'b0, 16'd0, 16'd0}, 16'd0, 16'd0},
		'{ROW_CFG,     1'b0, 1'b0, '0, 16'd3, 16'd2},
		'{ROW_FOLLOW,  1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FOLLOW,  1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FLIP,    1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FOLLOW,  1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FLIP,    1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FLIP,    1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FOLLOW,  1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FLIP,    1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FOLLOW,  1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FOLLOW,  1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FOLLOW,  1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_RESTART, 1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FOLLOW,  1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_CFG,     1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FOLLOW,  1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FLIP,    1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FOLLOW,  1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_CFG,     1'b0, 1'b0, '0, 16'hFFFF, 16'hFFFF},
		'{ROW_RESTART, 1'b1, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FLIP,    1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FOLLOW,  1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_CFG,     1'b0, 1'b0, '0, 16'd1, 16'd1},
		'{ROW_FOLLOW,  1'b0, 1'b0, '0, 16'd0, 16'd0},
		'{ROW_FLIP,    1'b0, 1'b0, '0, 16'd0, 16'd0}
	};

	prbs9_sync_error_checker_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_bit       (rx_bit),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.locked       (locked),
		.bit_mismatch (bit_mismatch),
		.errors_seen  (errors_seen),
		.matches_seen (matches_seen),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic next_prbs_bit();
		return lfsr_model[8] ^ lfsr_model[4];
	endfunction

	function automatic result_t predict_status(input logic rx, input logic rst);
		result_t r;
		logic    fb;
		logic    miss;
		miss = 1'b0;
		if (rst) begin
			lfsr_model = LFSR_SEED;
			lock_model = 1'b0;
		end else begin
			fb         = next_prbs_bit();
			lfsr_model = {lfsr_model[LFSR_W-2:0], fb};
			miss       = rx ^ fb;
			if (miss) begin
				miss_run = miss_run + 1'b1;
				hit_run  = '0;
			end else begin
				hit_run  = hit_run + 1'b1;
				miss_run = '0;
			end
			if (!lock_model) begin
				err_tally = '0;
				hit_tally = '0;
				if (hit_run >= sync_thr)
					lock_model = 1'b1;
				// While hunting, any miss throws away the alignment.
				if (miss) begin
					lfsr_model = LFSR_SEED;
					lock_model = 1'b0;
				end
			end else begin
				if (miss_run >= loss_thr)
					lock_model = 1'b0;
				// The bit that drops lock is still tallied.
				if (miss)
					err_tally = err_tally + 1'b1;
				else
					hit_tally = hit_tally + 1'b1;
			end
		end
		r.locked       = lock_model;
		r.bit_mismatch = miss;
		r.errors_seen  = err_tally;
		r.matches_seen = hit_tally;
		return r;
	endfunction

	task automatic send_beat(input logic b, input logic r, input logic typed,
		input result_t want);
		result_t pred;
		in_valid <= 1'b1;
		rx_bit   <= b;
		restart  <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = predict_status(b, r);
		status_due.push_back(typed ? want : pred);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		in_valid <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic program_thresholds(input logic [THR_W-1:0] s,
		input logic [THR_W-1:0] l);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SYNC_THRESHOLD;
		cfg_data  <= s;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sync_thr = s;
		cfg_index <= REG_LOSS_THRESHOLD;
		cfg_data  <= l;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		loss_thr = l;
		cfg_valid <= 1'b0;
	endtask

	task automatic report_fault(input string why, input result_t want, input result_t seen);
		fault_count++;
		if (fault_count <= REPORT_LIMIT)
			$display({"%0t %s: expected locked=%0b miss=%0b err=%0d hit=%0d,",
				" got locked=%0b miss=%0b err=%0d hit=%0d"},
				$time, why, want.locked, want.bit_mismatch, want.errors_seen,
				want.matches_seen, seen.locked, seen.bit_mismatch, seen.errors_seen,
				seen.matches_seen);
	endtask

	// The receiver picks a new stall pattern each time its random countdown runs out.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 15) != 0);
		endcase
	end

	always @(posedge clk) begin
		result_t want;
		result_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen = {locked, bit_mismatch, errors_seen, matches_seen};
			if (status_due.size() == 0) begin
				report_fault("result beat with nothing expected", '0, seen);
			end else begin
				want = status_due.pop_front();
				if (seen.locked !== want.locked ||
				    seen.bit_mismatch !== want.bit_mismatch ||
				    seen.errors_seen !== want.errors_seen ||
				    seen.matches_seen !== want.matches_seen)
					report_fault("result mismatch", want, seen);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[prbs9_sync_error_checker_top] ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned burst_left;
		int unsigned miss_burst;
		logic        flip;
		logic        b;
		logic        r;
		burst_left = $urandom_range(1, 40);
		miss_burst = 0;

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_CFG: begin
					drain_results();
					program_thresholds(directed_rows[i].sync_thr, directed_rows[i].loss_thr);
				end
				ROW_RESTART: send_beat(directed_rows[i].raw, 1'b1, directed_rows[i].typed,
					directed_rows[i].want);
				ROW_RAW: send_beat(directed_rows[i].raw, 1'b0, directed_rows[i].typed,
					directed_rows[i].want);
				ROW_FOLLOW: send_beat(next_prbs_bit(), 1'b0, 1'b0, '0);
				default: send_beat(!next_prbs_bit(), 1'b0, 1'b0, '0);
			endcase
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			if (p >= 6) begin
				phase_sync[p] = $urandom_range(1, 40);
				phase_loss[p] = $urandom_range(1, 30);
			end
			drain_results();
			program_thresholds(THR_W'(phase_sync[p]), THR_W'(phase_loss[p]));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Mostly a clean stream with sparse single misses and occasional error bursts
				// that can drop lock; a small share is plain noise.
				r = ($urandom_range(0, 79) == 0);
				if (miss_burst != 0) begin
					flip = 1'b1;
					miss_burst--;
				end else if ($urandom_range(0, 119) == 0) begin
					flip       = 1'b1;
					miss_burst = $urandom_range(1, 24);
				end else begin
					flip = ($urandom_range(0, 49) == 0);
				end
				if (r || $urandom_range(0, 15) == 0)
					b = 1'($urandom_range(0, 1));
				else
					b = next_prbs_bit() ^ flip;
				send_beat(b, r, 1'b0, '0);
				burst_left--;
				if (burst_left == 0) begin
					pause_sender($urandom_range(1, 6));
					burst_left = $urandom_range(1, 40);
				end
			end
		end

		drain_results();
		if (fault_count == 0)
			$display("[prbs9_sync_error_checker_top] OK");
		else
			$display("[prbs9_sync_error_checker_top] ERROR");
		$finish;
	end

endmodule
